@@ design/bss_pkg.sv @@
`timescale 1ns / 1ps

package bss_pkg;

  // set geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // operation codes; any other code acts as a lookup
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input beat, restart the scan
    logic step;      // issue the next entry read
    logic scan_end;  // latch scan outcome, aim the shift past the match
    logic shift_wr;  // write the previous read one place down
    logic finish;    // apply the operation and load the result register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic match;
    logic shift_done;
    logic out_free;
    logic is_delete;
  } dp_stat_t;

endpackage

@@ design/bss_ctrl.sv @@
`timescale 1ns / 1ps

module bss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bss_pkg::dp_stat_t stat,
  output bss_pkg::dp_cmd_t  cmd
);
  import bss_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.scan_end = 1'b1;
          state_next   = (stat.is_delete && stat.match) ? S_SHIFT : S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.step     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (stat.shift_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bss_datapath.sv @@
`timescale 1ns / 1ps

module bss_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  bss_pkg::dp_cmd_t                  cmd,
  output bss_pkg::dp_stat_t                 stat,
  input  logic [bss_pkg::OP_W-1:0]          op,
  input  logic signed [bss_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bss_pkg::ST_W-1:0]          status,
  output logic                              found,
  output logic [bss_pkg::IDX_W-1:0]         position,
  output logic [bss_pkg::CNT_W-1:0]         count
);
  import bss_pkg::*;

  // entry memory, one read and one write port
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rd_data;

  logic [OP_W-1:0]         op_r;
  logic signed [VAL_W-1:0] value_r;
  logic [CNT_W-1:0]        rd_idx;
  logic                    cmp_vld;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    hit;
  logic [IDX_W-1:0]        hit_pos;

  logic                    issue;
  logic                    match_now;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic [ST_W-1:0]         status_next;
  logic [CNT_W-1:0]        count_next;
  logic                    ins_wr;

  assign issue     = (rd_idx < count);
  assign match_now = cmp_vld && (rd_data == value_r);

  // status toward the controller
  always_comb begin
    stat.scan_done  = match_now || !issue;
    stat.match      = match_now;
    stat.shift_done = !issue && !cmp_vld;
    stat.out_free   = !out_valid || out_ready;
    stat.is_delete  = (op_r == OP_DELETE);
  end

  // apply the operation once the scan outcome is known
  always_comb begin
    status_next = ST_ABSENT;
    count_next  = count;
    ins_wr      = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (hit) begin
          status_next = ST_PRESENT;
        end else if (count < CAP_COUNT) begin
          status_next = ST_OK;
          count_next  = count + CNT_W'(1);
          ins_wr      = 1'b1;
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          status_next = ST_OK;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = hit ? ST_OK : ST_ABSENT;
      end
    endcase
  end

  // write port: shift moves an entry down, insert appends
  always_comb begin
    wr_en   = (cmd.shift_wr && cmp_vld) || (cmd.finish && ins_wr);
    wr_addr = cmd.shift_wr ? (cmp_idx - IDX_W'(1)) : count[IDX_W-1:0];
    wr_data = cmd.shift_wr ? rd_data : value_r;
  end

  // memory ports
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx[IDX_W-1:0]];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // scan and shift sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else if (cmd.load) begin
      op_r    <= op;
      value_r <= value;
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.scan_end) begin
      hit     <= match_now;
      hit_pos <= match_now ? cmp_idx : '0;
      rd_idx  <= {1'b0, cmp_idx} + CNT_W'(1);
      cmp_vld <= 1'b0;
    end else if (cmd.step) begin
      if (issue) begin
        rd_idx  <= rd_idx + CNT_W'(1);
        cmp_vld <= 1'b1;
        cmp_idx <= rd_idx[IDX_W-1:0];
      end else begin
        cmp_vld <= 1'b0;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      status    <= status_next;
      found     <= hit;
      position  <= hit_pos;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // count never runs past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count above capacity");

  // a result is never loaded over one still waiting
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // a successful delete drops the count by one
  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && op_r == OP_DELETE && hit) |=> (count == $past(count) - CNT_W'(1)))
    else $error("delete did not decrement count");

  // shift writes stay inside the occupied entries
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_wr && cmp_vld) |-> ({1'b0, cmp_idx} < count && cmp_idx != '0))
    else $error("shift write outside occupied range");

endmodule

@@ design/bounded_set_store.sv @@
`timescale 1ns / 1ps

// Bounded set of up to 16 signed 32-bit values, kept packed in insertion order.
// Each input beat carries an op (insert, delete, lookup; codes 2 and 3 look up) and a
// value, and yields one result beat with status, found flag, match position and
// the entry count afterwards. Membership is found by scanning the stored entries
// through a single memory read port, one entry per cycle; a delete of a present
// value then shifts the later entries down one place. The next beat is taken
// while a result still waits on the output register.
module bounded_set_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bss_pkg::OP_W-1:0]          op,
  input  logic signed [bss_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bss_pkg::ST_W-1:0]          status,
  output logic                              found,
  output logic [bss_pkg::IDX_W-1:0]         position,
  output logic [bss_pkg::CNT_W-1:0]         count
);
  import bss_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, compare and result
  bss_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .position  (position),
    .count     (count)
  );

endmodule
